/* hw/rtl/rrac_pkg.sv */
// shared types, constants and helpers for the rounded-rect alpha compositor
`default_nettype none

package rrac_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int RADIUS_BITS_DEF = 6;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 13;
  localparam int COLOR_W         = 24;
  localparam int SQRT_FRAC_SHIFT = 14;
  localparam int SQRT_STEP_BITS  = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WIN_LEFT      = 3'd0,
    REG_WIN_TOP       = 3'd1,
    REG_WIN_WIDTH     = 3'd2,
    REG_WIN_HEIGHT    = 3'd3,
    REG_CORNER_RADIUS = 3'd4,
    REG_WINDOW_ALPHA  = 3'd5
  } cfg_reg_t;

  // what travels alongside the coverage math
  typedef struct packed {
    logic [COLOR_W-1:0] src_color;
    logic [COLOR_W-1:0] under_color;
    logic               write;
    logic               corner;
  } side_t;

  // width of the squared distance (2lx+1)^2 + (2ly+1)^2
  function automatic int dsq_bits(input int rb);
    return 2 * rb + 3;
  endfunction

  // root of the scaled squared distance, radicand rounded up to an even width
  function automatic int root_bits(input int rb);
    int rw;
    rw = dsq_bits(rb) + SQRT_FRAC_SHIFT;
    return (rw + 1) / 2;
  endfunction

  // floor(x / 255), exact for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'd1 + 17'(x[15:8]);
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rrac_pix_if.sv */
// pixel input channel: coordinates, window color and color beneath
`default_nettype none

interface rrac_pix_if import rrac_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;
  logic [COLOR_W-1:0]    src_color;
  logic [COLOR_W-1:0]    under_color;

  modport source (output valid, output pix_x, output pix_y, output src_color,
                  output under_color, input ready);
  modport sink   (input valid, input pix_x, input pix_y, input src_color,
                  input under_color, output ready);

endinterface

`default_nettype wire

/* hw/rtl/rrac_res_if.sv */
// result channel: write strobe and composited color
`default_nettype none

interface rrac_res_if import rrac_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               write_enable;
  logic [COLOR_W-1:0] out_color;

  modport source (output valid, output write_enable, output out_color, input ready);
  modport sink   (input valid, input write_enable, input out_color, output ready);

endinterface

`default_nettype wire

/* hw/rtl/rrac_sqrt.sv */
// pipelined integer square root of the scaled corner distance
`default_nettype none

module rrac_sqrt import rrac_pkg::*; #(
  parameter  int RADIUS_BITS = RADIUS_BITS_DEF,
  localparam int DW          = dsq_bits(RADIUS_BITS),
  localparam int QW          = root_bits(RADIUS_BITS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] dsq,
  input  side_t         in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] root,
  output side_t         out_side
);

  localparam int RWE = 2 * QW;
  localparam int NSQ = (QW + SQRT_STEP_BITS - 1) / SQRT_STEP_BITS;

  logic           v_r    [NSQ];
  logic           rdy    [NSQ];
  logic [RWE-1:0] rem_r  [NSQ];
  logic [QW-1:0]  q_r    [NSQ];
  side_t          side_r [NSQ];

  for (genvar s = 0; s < NSQ; s++) begin : g_stage
    logic           v_i;
    logic [RWE-1:0] rem_i;
    logic [QW-1:0]  q_i;
    side_t          side_i;
    logic [RWE-1:0] rem_o;
    logic [QW-1:0]  q_o;

    if (s == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = RWE'({dsq, {SQRT_FRAC_SHIFT{1'b0}}});
      assign q_i    = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign q_i    = q_r[s-1];
      assign side_i = side_r[s-1];
    end

    if (s == NSQ - 1) begin : g_last_rdy
      assign rdy[s] = !v_r[s] || out_ready;
    end else begin : g_mid_rdy
      assign rdy[s] = !v_r[s] || rdy[s+1];
    end

    // restoring digit recurrence, SQRT_STEP_BITS root bits per stage
    always_comb begin
      logic [RWE:0] trial;
      int           bi;
      rem_o = rem_i;
      q_o   = q_i;
      for (int k = 0; k < SQRT_STEP_BITS; k++) begin
        bi    = QW - 1 - s * SQRT_STEP_BITS - k;
        trial = '0;
        if (bi >= 0) begin
          trial = ((RWE+1)'(q_o) << (bi + 1)) + ((RWE+1)'(1) << (2 * bi));
          if ({1'b0, rem_o} >= trial) begin
            rem_o = rem_o - RWE'(trial);
            q_o   = q_o | (QW'(1) << bi);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        rem_r[s]  <= rem_o;
        q_r[s]    <= q_o;
        side_r[s] <= side_i;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSQ-1];
  assign root      = q_r[NSQ-1];
  assign out_side  = side_r[NSQ-1];

endmodule

`default_nettype wire

/* hw/rtl/rounded_rect_alpha_composite.sv */
// Rounded-rectangle window compositor. One pixel enters per clock and one
// result leaves per clock while result.ready is high; a pixel outside the
// window, or a corner pixel with no coverage, comes back with write_enable
// low and a zero color. R = RADIUS_BITS + 9 is the number of root bits of
// the corner distance; the square root pipeline sets the depth, four root
// bits per stage. A pipeline stage holds while the next is full and stalled,
// so a stalled result still lets pixels enter until every stage is occupied.
// Registers are written through cfg_we/cfg_index/cfg_data by the user only
// while no pixel is in flight; the block itself does not enforce it.
`default_nettype none

module rounded_rect_alpha_composite import rrac_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  rrac_pix_if.sink               pixel,
  rrac_res_if.source             result
);

  localparam int XW = ((COORD_BITS + 1 > CFG_DATA_W) ? COORD_BITS + 1 : CFG_DATA_W) + 1;
  localparam int RB = RADIUS_BITS;
  localparam int DW = dsq_bits(RADIUS_BITS);
  localparam int QW = root_bits(RADIUS_BITS);
  localparam int EW = QW + 2;

  // configuration registers
  logic signed [CFG_DATA_W-1:0] win_left;
  logic signed [CFG_DATA_W-1:0] win_top;
  logic        [CFG_DATA_W-1:0] win_width;
  logic        [CFG_DATA_W-1:0] win_height;
  logic        [RB-1:0]         corner_radius;
  logic        [7:0]            window_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left      <= '0;
      win_top       <= '0;
      win_width     <= CFG_DATA_W'(1);
      win_height    <= CFG_DATA_W'(1);
      corner_radius <= '0;
      window_alpha  <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIN_LEFT:      win_left      <= cfg_data;
        REG_WIN_TOP:       win_top       <= cfg_data;
        REG_WIN_WIDTH:     win_width     <= cfg_data;
        REG_WIN_HEIGHT:    win_height    <= cfg_data;
        REG_CORNER_RADIUS: corner_radius <= RB'(cfg_data[5:0]);
        REG_WINDOW_ALPHA:  window_alpha  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // pipeline registers
  logic                 v1, v2, v3, v4, v5, v6, v7;
  logic                 rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8;
  logic signed [XW-1:0] xx1, yy1;
  side_t                side1, side2, side3, side4, side5, side6, side7;
  logic [RB-1:0]        lx2, ly2;
  logic [DW-1:0]        dsq3;
  logic [7:0]           cov4;
  logic [15:0]          prod5;
  logic [7:0]           a6;
  logic [15:0]          numer7 [3];
  logic                 copy7;
  logic                 out_v;
  logic                 out_we;
  logic [COLOR_W-1:0]   out_col;

  logic                 sq_in_ready;
  logic                 sq_valid;
  logic [QW-1:0]        sq_root;
  side_t                sq_side;

  assign rdy8 = !out_v || result.ready;
  assign rdy7 = !v7 || rdy8;
  assign rdy6 = !v6 || rdy7;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || sq_in_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign pixel.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      v5    <= 1'b0;
      v6    <= 1'b0;
      v7    <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (rdy1) v1 <= pixel.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= sq_valid;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
      if (rdy8) out_v <= v7;
    end
  end

  // stage 1: offsets inside the window frame
  always_ff @(posedge clk) begin
    if (rdy1) begin
      xx1                <= XW'($signed({1'b0, pixel.pix_x})) - XW'(win_left);
      yy1                <= XW'($signed({1'b0, pixel.pix_y})) - XW'(win_top);
      side1.src_color    <= pixel.src_color;
      side1.under_color  <= pixel.under_color;
      side1.write        <= 1'b0;
      side1.corner       <= 1'b0;
    end
  end

  // stage 2: bounds, body rows and corner offsets
  logic signed [XW-1:0] wv, hv, rv, wr, hr, lx_full, ly_full;
  logic                 in_frame, in_body, lx_ok, ly_ok;

  always_comb begin
    wv       = $signed(XW'({1'b0, win_width}));
    hv       = $signed(XW'({1'b0, win_height}));
    rv       = $signed(XW'({1'b0, corner_radius}));
    wr       = wv - rv;
    hr       = hv - rv;
    in_frame = (xx1 >= 0) && (xx1 < wv) && (yy1 >= 0) && (yy1 < hv);
    in_body  = (yy1 >= rv) && (yy1 < hr);
    // left band wins over right, top over bottom
    lx_ok   = 1'b1;
    lx_full = '0;
    if (xx1 < rv) begin
      lx_full = rv - xx1 - XW'(1);
    end else if (xx1 >= wr) begin
      lx_full = xx1 - wr;
    end else begin
      lx_ok = 1'b0;
    end
    ly_ok   = 1'b1;
    ly_full = '0;
    if (yy1 < rv) begin
      ly_full = rv - yy1 - XW'(1);
    end else if (yy1 >= hr) begin
      ly_full = yy1 - hr;
    end else begin
      ly_ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      lx2               <= lx_full[RB-1:0];
      ly2               <= ly_full[RB-1:0];
      side2.src_color   <= side1.src_color;
      side2.under_color <= side1.under_color;
      side2.write       <= in_frame;
      side2.corner      <= in_frame && !in_body && lx_ok && ly_ok;
    end
  end

  // stage 3: squared distance in half-pixel units
  logic [RB:0]     ax, ay;
  logic [2*RB+1:0] axx, ayy;

  always_comb begin
    ax  = {lx2, 1'b1};
    ay  = {ly2, 1'b1};
    axx = (2*RB+2)'(ax) * (2*RB+2)'(ax);
    ayy = (2*RB+2)'(ay) * (2*RB+2)'(ay);
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      dsq3  <= DW'(axx) + DW'(ayy);
      side3 <= side2;
    end
  end

  rrac_sqrt #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_ready  (sq_in_ready),
    .dsq       (dsq3),
    .in_side   (side3),
    .out_valid (sq_valid),
    .out_ready (rdy4),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // stage 4: coverage from the signed edge distance in 1/256 pixel
  logic signed [EW-1:0] edge_dist, edge_bias;
  logic [7:0]           cov;

  always_comb begin
    edge_dist = $signed(EW'({corner_radius, 8'd0})) - $signed(EW'(sq_root));
    edge_bias = edge_dist + EW'(127);
    if (!sq_side.corner || edge_dist >= EW'(128)) begin
      cov = 8'd255;
    end else if (edge_dist <= -EW'(128)) begin
      cov = 8'd0;
    end else begin
      cov = edge_bias[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      cov4              <= cov;
      side4.src_color   <= sq_side.src_color;
      side4.under_color <= sq_side.under_color;
      side4.corner      <= sq_side.corner;
      side4.write       <= sq_side.write && (cov != 8'd0);
    end
  end

  // stage 5: coverage times window alpha
  always_ff @(posedge clk) begin
    if (rdy5) begin
      prod5 <= 16'(cov4) * 16'(window_alpha);
      side5 <= side4;
    end
  end

  // stage 6: effective alpha
  always_ff @(posedge clk) begin
    if (rdy6) begin
      a6    <= div255(prod5);
      side6 <= side5;
    end
  end

  // stage 7: per-channel blend numerators
  always_ff @(posedge clk) begin
    if (rdy7) begin
      for (int c = 0; c < 3; c++) begin
        numer7[c] <= 16'(side6.src_color[8*c +: 8]) * 16'(a6)
                   + 16'(side6.under_color[8*c +: 8]) * 16'(8'd255 - a6)
                   + 16'd127;
      end
      copy7 <= (a6 == 8'd255);
      side7 <= side6;
    end
  end

  // stage 8: output register
  always_ff @(posedge clk) begin
    if (rdy8) begin
      out_we <= side7.write;
      if (!side7.write) begin
        out_col <= '0;
      end else if (copy7) begin
        out_col <= side7.src_color;
      end else begin
        out_col <= {div255(numer7[2]), div255(numer7[1]), div255(numer7[0])};
      end
    end
  end

  assign result.valid        = out_v;
  assign result.write_enable = out_we;
  assign result.out_color    = out_col;

  a_skip_is_blank: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.write_enable |-> result.out_color == '0)
    else $error("unwritten pixel carries a color");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> v1 && result.valid)
    else $error("input stalled with a bubble in the first stage");

  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    v1 && !rdy2 |=> v1 && $stable(xx1) && $stable(yy1))
    else $error("first stage lost or changed a held beat");

  a_body_full_cov: assert property (@(posedge clk) disable iff (rst)
    v4 && !side4.corner |-> cov4 == 8'd255)
    else $error("non-corner pixel got partial coverage");

endmodule

`default_nettype wire

/* dv/testbench.sv */
// testbench for the rounded-rect alpha compositor: directed and random pixels against a predictor
`default_nettype none

module testbench;
  import rrac_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW         = COORD_BITS_DEF;
  localparam int CYCLE_CAP  = 400000;
  localparam int SHOW_LIMIT = 40;

  typedef struct packed {
    logic [CW-1:0]      x;
    logic [CW-1:0]      y;
    logic [COLOR_W-1:0] src;
    logic [COLOR_W-1:0] under;
  } pix_beat_t;

  typedef struct packed {
    logic               we;
    logic [COLOR_W-1:0] color;
  } composite_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  rrac_pix_if #(.COORD_BITS(CW)) pixel_ch ();
  rrac_res_if                    result_ch ();

  rounded_rect_alpha_composite dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pixel    (pixel_ch),
    .result   (result_ch)
  );

  // shadow copy of the window registers
  logic signed [12:0] win_left_q;
  logic signed [12:0] win_top_q;
  logic [12:0]        win_width_q;
  logic [12:0]        win_height_q;
  logic [5:0]         radius_q;
  logic [7:0]         alpha_q;

  pix_beat_t  pixels_to_send[$];
  composite_t composites_due[$];
  pix_beat_t  next_pix;
  pix_beat_t  seen_pix;
  composite_t want;

  int  send_idle;
  int  sink_stall;
  int  bad_beats;
  int  cycles;
  bit  hold_feed;
  bit  calm_source;
  bit  calm_sink;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(sqrt(v)) by setting root bits from the top down
  function automatic longint root_floor(longint v);
    longint root;
    longint trial;
    root = 0;
    for (int i = 16; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic composite_t composite_pixel(pix_beat_t p);
    int xx, yy, w, h, r, lx, ly, ax, ay, e, cov, a, sc, dc, ch;
    longint dq;
    composite_t o;
    o  = '0;
    w  = int'(win_width_q);
    h  = int'(win_height_q);
    r  = int'(radius_q);
    xx = int'(p.x) - int'(win_left_q);
    yy = int'(p.y) - int'(win_top_q);
    if (xx < 0 || xx >= w || yy < 0 || yy >= h) return o;
    a = int'(alpha_q);
    if (!(yy >= r && yy < h - r)) begin
      lx = (xx < r) ? r - 1 - xx : ((xx >= w - r) ? xx - (w - r) : -1);
      ly = (yy < r) ? r - 1 - yy : ((yy >= h - r) ? yy - (h - r) : -1);
      if (lx >= 0 && ly >= 0) begin
        ax  = 2 * lx + 1;
        ay  = 2 * ly + 1;
        // distance to the circle center in Q.8 pixels
        dq  = root_floor(longint'(ax * ax + ay * ay) << 14);
        e   = r * 256 - int'(dq);
        if (e >= 128) cov = 255;
        else if (e <= -128) cov = 0;
        else cov = (e + 128) * 255 / 256;
        if (cov == 0) return o;
        a = cov * int'(alpha_q) / 255;
      end
    end
    o.we = 1'b1;
    if (a >= 255) begin
      o.color = p.src;
    end else begin
      for (int k = 0; k < 3; k++) begin
        sc = int'(p.src[8*k +: 8]);
        dc = int'(p.under[8*k +: 8]);
        ch = (sc * a + dc * (255 - a) + 127) / 255;
        o.color[8*k +: 8] = 8'(ch);
      end
    end
    return o;
  endfunction

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // pixel beats out
  always @(posedge clk) begin
    if (rst) begin
      pixel_ch.valid <= 1'b0;
      send_idle      <= 0;
    end else if (!pixel_ch.valid || pixel_ch.ready) begin
      if (send_idle > 0) begin
        pixel_ch.valid <= 1'b0;
        send_idle      <= send_idle - 1;
      end else if (pixels_to_send.size() > 0 && !hold_feed) begin
        next_pix              = pixels_to_send.pop_front();
        pixel_ch.valid       <= 1'b1;
        pixel_ch.pix_x       <= next_pix.x;
        pixel_ch.pix_y       <= next_pix.y;
        pixel_ch.src_color   <= next_pix.src;
        pixel_ch.under_color <= next_pix.under;
        send_idle            <= calm_source ? 0 : gap_len();
      end else begin
        pixel_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      sink_stall      <= 0;
    end else if (sink_stall > 0) begin
      result_ch.ready <= 1'b0;
      sink_stall      <= sink_stall - 1;
    end else begin
      result_ch.ready <= 1'b1;
      sink_stall      <= calm_sink ? 0 : gap_len();
    end
  end

  // predict on every accepted pixel, check every accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_ch.valid && pixel_ch.ready) begin
        seen_pix.x     = pixel_ch.pix_x;
        seen_pix.y     = pixel_ch.pix_y;
        seen_pix.src   = pixel_ch.src_color;
        seen_pix.under = pixel_ch.under_color;
        composites_due.push_back(composite_pixel(seen_pix));
      end
      if (result_ch.valid && result_ch.ready) begin
        if (composites_due.size() == 0) begin
          bad_beats++;
          if (bad_beats <= SHOW_LIMIT)
            $display("%0t: unexpected result beat, got we=%0b color=%06h", $time,
                     result_ch.write_enable, result_ch.out_color);
        end else begin
          want = composites_due.pop_front();
          if (result_ch.write_enable !== want.we) begin
            bad_beats++;
            if (bad_beats <= SHOW_LIMIT)
              $display("%0t: write_enable expected %0b, got %0b", $time, want.we,
                       result_ch.write_enable);
          end
          if (result_ch.out_color !== want.color) begin
            bad_beats++;
            if (bad_beats <= SHOW_LIMIT)
              $display("%0t: out_color expected %06h, got %06h", $time, want.color,
                       result_ch.out_color);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // returns right after a rising edge
  task automatic wait_drained();
    do @(negedge clk);
    while (pixels_to_send.size() != 0 || pixel_ch.valid || composites_due.size() != 0);
    @(posedge clk);
  endtask

  task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_WIN_LEFT:      win_left_q   = val;
      REG_WIN_TOP:       win_top_q    = val;
      REG_WIN_WIDTH:     win_width_q  = val;
      REG_WIN_HEIGHT:    win_height_q = val;
      REG_CORNER_RADIUS: radius_q     = val[5:0];
      REG_WINDOW_ALPHA:  alpha_q      = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // ends at a falling edge so the caller can queue pixels right away
  task automatic configure(int left, int top, int width, int height, int radius, int alpha);
    wait_drained();
    set_reg(REG_WIN_LEFT, 13'(left));
    set_reg(REG_WIN_TOP, 13'(top));
    set_reg(REG_WIN_WIDTH, 13'(width));
    set_reg(REG_WIN_HEIGHT, 13'(height));
    set_reg(REG_CORNER_RADIUS, 13'(radius));
    set_reg(REG_WINDOW_ALPHA, 13'(alpha));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_pixel(int x, int y, int src, int under);
    pix_beat_t p;
    p.x     = CW'(x);
    p.y     = CW'(y);
    p.src   = COLOR_W'(src);
    p.under = COLOR_W'(under);
    pixels_to_send.push_back(p);
  endtask

  // stop feeding until the pipeline has emptied
  task automatic pause_feed();
    hold_feed = 1'b1;
    do @(negedge clk);
    while (pixel_ch.valid || composites_due.size() != 0);
    hold_feed = 1'b0;
  endtask

  function automatic int pick_pos();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return -4096;
    if (roll == 1) return 4095;
    return int'($urandom_range(0, 4200)) - 100;
  endfunction

  function automatic int pick_size();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 4096;
    if (roll == 1) return 1;
    if (roll == 2) return $urandom_range(1, 4096);
    return $urandom_range(2, 150);
  endfunction

  function automatic int pick_radius();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 0;
    if (roll == 1) return 63;
    return $urandom_range(1, 40);
  endfunction

  function automatic int pick_alpha();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 0;
    if (roll < 3) return 255;
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return COLOR_W'($urandom());
  endfunction

  // offset in or just past the corner band at either end of a span
  function automatic int corner_offset(int span, int r);
    int d;
    d = $urandom_range(0, r + 1);
    return $urandom_range(0, 1) ? d : span - 1 - d;
  endfunction

  function automatic pix_beat_t near_pixel(int left, int top, int w, int h, int r);
    int mode, xx, yy;
    pix_beat_t p;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      xx = int'($urandom_range(0, 4095)) - left;
      yy = int'($urandom_range(0, 4095)) - top;
    end else if (mode < 6) begin
      xx = corner_offset(w, r);
      yy = corner_offset(h, r);
    end else begin
      xx = int'($urandom_range(0, w + 3)) - 2;
      yy = int'($urandom_range(0, h + 3)) - 2;
    end
    p.x     = CW'(left + xx);
    p.y     = CW'(top + yy);
    p.src   = pick_color();
    p.under = pick_color();
    return p;
  endfunction

  initial begin : stimulus
    int lf, tp, wd, ht, rd, al;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = REG_WIN_LEFT;
    cfg_data             = '0;
    pixel_ch.valid       = 1'b0;
    pixel_ch.pix_x       = '0;
    pixel_ch.pix_y       = '0;
    pixel_ch.src_color   = '0;
    pixel_ch.under_color = '0;
    result_ch.ready      = 1'b0;
    win_left_q           = '0;
    win_top_q            = '0;
    win_width_q          = 13'd1;
    win_height_q         = 13'd1;
    radius_q             = '0;
    alpha_q              = 8'd255;
    hold_feed            = 1'b0;
    calm_source          = 1'b0;
    calm_sink            = 1'b0;
    bad_beats            = 0;
    cycles               = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // opaque window with radius 10 at (100,50), 40x30
    configure(100, 50, 40, 30, 10, 255);
    queue_pixel(99, 60, 'hffffff, 'h000000);   // left of the window
    queue_pixel(140, 60, 'hffffff, 'h000000);  // right of the window
    queue_pixel(120, 49, 'hffffff, 'h000000);  // above
    queue_pixel(120, 80, 'hffffff, 'h000000);  // below
    queue_pixel(120, 60, 'h123456, 'habcdef);  // interior copy
    queue_pixel(100, 50, 'hffffff, 'h000000);  // corner tip, no coverage
    queue_pixel(103, 53, 'hffffff, 'h000000);  // inside the arc
    queue_pixel(102, 52, 'hffffff, 'h000000);  // just outside the arc
    queue_pixel(102, 53, 'hffffff, 'h000000);  // on the arc, partial
    queue_pixel(139, 79, 'hffffff, 'h000000);
    queue_pixel(136, 76, 'h00ff00, 'hff00ff);
    queue_pixel(137, 76, 'hffffff, 'h000000);

    // zero alpha: covered pixels take the color beneath
    configure(100, 50, 40, 30, 10, 0);
    queue_pixel(120, 60, 'hffffff, 'h5a5a5a);
    queue_pixel(102, 53, 'hffffff, 'ha5a5a5);

    configure(100, 50, 40, 30, 10, 128);
    queue_pixel(120, 60, 'hff8000, 'h0080ff);
    queue_pixel(102, 53, 'hff8000, 'h0080ff);

    // radius far beyond the window size
    configure(10, 10, 5, 3, 63, 200);
    queue_pixel(12, 11, 'hffffff, 'h000000);
    queue_pixel(10, 10, 'hffffff, 'h000000);
    queue_pixel(14, 12, 'hffffff, 'h000000);

    // zero width covers nothing
    configure(10, 10, 0, 3, 0, 255);
    queue_pixel(10, 10, 'hffffff, 'h000000);

    configure(-4096, -4096, 4096, 4096, 0, 255);
    queue_pixel(0, 0, 'hffffff, 'h000000);
    configure(4095, 4095, 4096, 4096, 63, 1);
    queue_pixel(4095, 4095, 'hffffff, 'h000000);
    configure(0, 0, 4096, 4096, 0, 255);
    queue_pixel(0, 0, 'h000000, 'hffffff);
    queue_pixel(4095, 4095, 'hffffff, 'h000000);

    for (int ph = 0; ph < 16; ph++) begin
      lf = pick_pos();
      tp = pick_pos();
      wd = pick_size();
      ht = pick_size();
      rd = pick_radius();
      al = pick_alpha();
      configure(lf, tp, wd, ht, rd, al);
      calm_source = ($urandom_range(0, 3) == 0);
      calm_sink   = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 50; i++)
        pixels_to_send.push_back(near_pixel(lf, tp, wd, ht, rd));
      if (ph % 5 == 2) begin
        do @(negedge clk);
        while (pixels_to_send.size() > 25);
        pause_feed();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (bad_beats == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/rrac_pkg.sv
hw/rtl/rrac_pix_if.sv
hw/rtl/rrac_res_if.sv
hw/rtl/rrac_sqrt.sv
hw/rtl/rounded_rect_alpha_composite.sv
dv/testbench.sv
